@@ hdl/wnes_pkg.sv @@
// Package for the weighted nearest-entry search core.
// Holds widths, field offsets, function codes and the datapath control struct.
// No dependencies.
`timescale 1ns / 1ps

package wnes_pkg;

  localparam int MAX_ENTRIES    = 64;
  localparam int NUM_DIMENSIONS = 16;
  localparam int FEATS          = 6;

  localparam int FEAT_W     = 16;
  localparam int FEAT_SEL_W = $clog2(FEATS);
  localparam int ROW_W      = FEATS * FEAT_W;
  localparam int ENT_IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int MASK_W     = 16;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int DIM_W      = 16;
  localparam int SQ_W       = 2 * FEAT_W;
  localparam int PROD_W     = SQ_W + FEAT_W;
  localparam int DIST_W     = 51;

  // Input item tdata layout, lowest bits first.
  localparam int IN_IDX_W    = 6;
  localparam int IN_IDX_LSB  = 0;
  localparam int IN_DIM_LSB  = IN_IDX_LSB + IN_IDX_W;
  localparam int IN_FEAT_LSB = IN_DIM_LSB + DIM_W;
  localparam int IN_BITS     = IN_FEAT_LSB + ROW_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result item tdata layout, lowest bits first.
  localparam int OUT_IDX_W   = 6;
  localparam int OUT_BITS    = OUT_IDX_W + DIST_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_W = 7;

  typedef enum logic [1:0] {
    FN_TARGETS = 2'd0,
    FN_WEIGHTS = 2'd1,
    FN_MASK    = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  typedef struct packed {
    logic                  acc_clr;
    logic                  diff_en;
    logic                  sq_en;
    logic                  wmul_en;
    logic                  acc_en;
    logic [FEAT_SEL_W-1:0] feat_sel;
  } dist_ctrl_t;

endpackage

@@ hdl/weighted_nearest_entry_search_core.sv @@
// Top level of the weighted nearest-entry search core: entry tables, sequencer,
// best-entry tracking and result register. Depends on wnes_pkg, wnes_ram, wnes_dist.
`timescale 1ns / 1ps

// The core keeps a table of up to 64 entries, each with six Q4.12 targets, six
// Q8.8 weights and a dimension mask (zero means allowed everywhere). Items on the
// input stream carry a function code in s_tuser: write targets, write weights,
// write mask, or query. A write item gives no result, and the input stays ready
// for the next item. A query walks the first entry_count entries (clamped to 64)
// and returns one result item with the first entry of strictly smallest weighted
// squared distance, or found = 0 when no entry is allowed. All distance products
// run through one shared multiplier that does two products per feature. The
// input side is not ready while a query runs. The result register frees the
// output side: a new item is taken while a finished result still waits, and a
// query only stalls at its end if the previous result has not yet been taken.
// entry_count is to be written through cfg_we/cfg_wdata only while the core is
// idle; the core itself does not enforce this. Reading an entry that was never
// written returns unknown distances.

module weighted_nearest_entry_search_core
  import wnes_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Configuration: entry_count.
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // Input items.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata fields, low bit first: entry_index, dimension_word, humidity,
  // temperature, weirdness, erosion, elevation, surface_proximity, zero pad.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser fields: func.
  input  logic [1:0]             s_tuser,
  // Result items.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata fields, low bit first: best_index, best_distance, zero pad.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // tuser fields: found.
  output logic                   m_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SQ,
    S_WMUL,
    S_ACC,
    S_DONE
  } state_t;

  localparam logic [FEAT_SEL_W-1:0] LAST_FEAT = FEAT_SEL_W'(FEATS - 1);
  localparam logic [CNT_W-1:0]      CNT_MAX   = CNT_W'(MAX_ENTRIES);

  state_t            state;
  logic [CFG_W-1:0]  entry_count;
  logic [CNT_W-1:0]  n_lim;
  logic [CNT_W-1:0]  e;
  logic [FEAT_SEL_W-1:0] k;
  logic [DIM_W-1:0]  qdim;
  logic [ROW_W-1:0]  qfeat;
  logic              have;
  logic [ENT_IDX_W-1:0] best_i;
  logic [DIST_W-1:0] best_d;
  logic              out_found;
  logic [OUT_IDX_W-1:0] out_idx;
  logic [DIST_W-1:0] out_dist;

  logic              accept;
  func_t             in_func;
  logic [IN_IDX_W-1:0] in_idx;
  logic              in_idx_ok;
  logic [CNT_W-1:0]  n_clamp;
  logic [CNT_W-1:0]  e_inc;
  logic              last_entry;
  logic              out_free;
  logic              allowed;
  logic              better;
  dist_ctrl_t        ctrl;
  logic [ROW_W-1:0]  tgt_rd;
  logic [ROW_W-1:0]  wgt_rd;
  logic [MASK_W-1:0] mask_rd;
  logic [DIST_W-1:0] acc_sum;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_func  = func_t'(s_tuser);
  assign in_idx   = s_tdata[IN_IDX_LSB +: IN_IDX_W];
  assign in_idx_ok = (CNT_W'(in_idx) < CNT_MAX);

  // Clamp the register to the table size.
  assign n_clamp = (CNT_W'(entry_count) > CNT_MAX) ? CNT_MAX : CNT_W'(entry_count);

  assign e_inc      = e + 1'b1;
  assign last_entry = (e_inc == n_lim);
  assign out_free   = !m_tvalid || m_tready;

  // A dimension number beyond the mask only matches all-dimension entries.
  assign allowed = (mask_rd == '0) ||
                   ((qdim < DIM_W'(NUM_DIMENSIONS)) && (qdim < DIM_W'(MASK_W)) &&
                    mask_rd[qdim[MASK_IDX_W-1:0]]);

  assign better = !have || (acc_sum < best_d);

  // Entry tables, one row per entry, read at the entry under search.
  wnes_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_tgt_ram (
    .clk   (clk),
    .we    (accept && (in_func == FN_TARGETS) && in_idx_ok),
    .waddr (in_idx[ENT_IDX_W-1:0]),
    .wdata (s_tdata[IN_FEAT_LSB +: ROW_W]),
    .raddr (e[ENT_IDX_W-1:0]),
    .rdata (tgt_rd)
  );

  wnes_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_wgt_ram (
    .clk   (clk),
    .we    (accept && (in_func == FN_WEIGHTS) && in_idx_ok),
    .waddr (in_idx[ENT_IDX_W-1:0]),
    .wdata (s_tdata[IN_FEAT_LSB +: ROW_W]),
    .raddr (e[ENT_IDX_W-1:0]),
    .rdata (wgt_rd)
  );

  wnes_ram #(.WIDTH(MASK_W), .DEPTH(MAX_ENTRIES)) u_mask_ram (
    .clk   (clk),
    .we    (accept && (in_func == FN_MASK) && in_idx_ok),
    .waddr (in_idx[ENT_IDX_W-1:0]),
    .wdata (s_tdata[IN_DIM_LSB +: MASK_W]),
    .raddr (e[ENT_IDX_W-1:0]),
    .rdata (mask_rd)
  );

  wnes_dist u_dist (
    .clk        (clk),
    .ctrl       (ctrl),
    .query_feat (qfeat),
    .tgt_row    (tgt_rd),
    .wgt_row    (wgt_rd),
    .acc_sum    (acc_sum)
  );

  // Per feature: square, weight, then accumulate while taking the next difference.
  always_comb begin
    ctrl = '0;
    unique case (state)
      S_CHECK: begin
        if (allowed) begin
          ctrl.acc_clr  = 1'b1;
          ctrl.diff_en  = 1'b1;
          ctrl.feat_sel = '0;
        end
      end
      S_SQ: begin
        ctrl.sq_en = 1'b1;
      end
      S_WMUL: begin
        ctrl.wmul_en  = 1'b1;
        ctrl.feat_sel = k;
      end
      S_ACC: begin
        ctrl.acc_en = 1'b1;
        if (k != LAST_FEAT) begin
          ctrl.diff_en  = 1'b1;
          ctrl.feat_sel = k + 1'b1;
        end
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      entry_count <= '0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_wdata;
      end
      // Post a finished result, or drop the one just taken.
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_func == FN_QUERY)) begin
            qdim   <= s_tdata[IN_DIM_LSB +: DIM_W];
            qfeat  <= s_tdata[IN_FEAT_LSB +: ROW_W];
            n_lim  <= n_clamp;
            e      <= '0;
            have   <= 1'b0;
            best_i <= '0;
            best_d <= '0;
            state  <= (n_clamp == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          // Wait out the registered RAM read.
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (allowed) begin
            k     <= '0;
            state <= S_SQ;
          end else if (last_entry) begin
            state <= S_DONE;
          end else begin
            e     <= e_inc;
            state <= S_READ;
          end
        end
        S_SQ: begin
          state <= S_WMUL;
        end
        S_WMUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (k != LAST_FEAT) begin
            k     <= k + 1'b1;
            state <= S_SQ;
          end else begin
            // Strictly smaller wins, so the lowest index holds on ties.
            if (better) begin
              have   <= 1'b1;
              best_i <= e[ENT_IDX_W-1:0];
              best_d <= acc_sum;
            end
            if (last_entry) begin
              state <= S_DONE;
            end else begin
              e     <= e_inc;
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          // Hold until the result register is free.
          if (out_free) begin
            out_found <= have;
            out_idx   <= OUT_IDX_W'(best_i);
            out_dist  <= best_d;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_dist, out_idx};
  assign m_tuser = out_found;

  // A not-found result carries zero index and distance.
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found result with nonzero payload");

  // The search never addresses an entry at or past the clamped count.
  a_entry_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_READ) || (state == S_CHECK) || (state == S_SQ) ||
     (state == S_WMUL) || (state == S_ACC)) |-> (e < n_lim))
    else $error("entry pointer beyond count");

  // A query item blocks the input for at least the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == FN_QUERY)) |=> !s_tready)
    else $error("input ready right after a query item");

  // A found result never points at an entry beyond the count.
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && have) |-> (CNT_W'(best_i) < n_lim))
    else $error("best entry beyond count");

endmodule

@@ hdl/wnes_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module wnes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/wnes_dist.sv @@
// Shared distance unit: absolute difference, one multiplier used for the square
// and for the weight product, and the running sum. Depends on wnes_pkg.
`timescale 1ns / 1ps

module wnes_dist
  import wnes_pkg::*;
(
  input  logic              clk,
  input  dist_ctrl_t        ctrl,
  input  logic [ROW_W-1:0]  query_feat,
  input  logic [ROW_W-1:0]  tgt_row,
  input  logic [ROW_W-1:0]  wgt_row,
  output logic [DIST_W-1:0] acc_sum
);

  logic [FEAT_W-1:0] tgt [FEATS];
  logic [FEAT_W-1:0] qf  [FEATS];
  logic [FEAT_W-1:0] wgt [FEATS];
  logic [FEAT_W-1:0] tgt_sel;
  logic [FEAT_W-1:0] qf_sel;
  logic [FEAT_W:0]   diff;
  logic [FEAT_W:0]   diff_abs;
  logic [FEAT_W-1:0] areg;
  logic [SQ_W-1:0]   mul_a;
  logic [FEAT_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_res;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] acc;

  always_comb begin
    for (int k = 0; k < FEATS; k++) begin
      tgt[k] = tgt_row[k*FEAT_W +: FEAT_W];
      qf[k]  = query_feat[k*FEAT_W +: FEAT_W];
      wgt[k] = wgt_row[k*FEAT_W +: FEAT_W];
    end
  end

  assign tgt_sel  = tgt[ctrl.feat_sel];
  assign qf_sel   = qf[ctrl.feat_sel];
  assign diff     = {tgt_sel[FEAT_W-1], tgt_sel} - {qf_sel[FEAT_W-1], qf_sel};
  assign diff_abs = diff[FEAT_W] ? (~diff + 1'b1) : diff;

  // One multiplier: |d| * |d| first, then square * weight.
  assign mul_a   = ctrl.sq_en ? {{(SQ_W-FEAT_W){1'b0}}, areg} : prod[SQ_W-1:0];
  assign mul_b   = ctrl.sq_en ? areg : wgt[ctrl.feat_sel];
  assign mul_res = mul_a * mul_b;

  assign acc_sum = acc + DIST_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      areg <= diff_abs[FEAT_W-1:0];
    end
    if (ctrl.sq_en || ctrl.wmul_en) begin
      prod <= mul_res;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc_sum;
    end
  end

endmodule

@@ dv/weighted_nearest_entry_search_core_test.sv @@
// Self-checking testbench for weighted_nearest_entry_search_core.
// Streams table writes and searches with bursty input and a stalling result side,
// and checks every result against its own table shadow. Depends on wnes_pkg.
`timescale 1ns / 1ps

module weighted_nearest_entry_search_core_test;
  import wnes_pkg::*;

  localparam int RESET_CYCLES  = 8;
  // Allow for a full 64-entry search plus the longest result stall and the
  // longest sender gap, then take that several times over.
  localparam int QUIET_LIMIT   = 8000;
  // Settling time after the last item and result, before touching entry_count.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int MAX_REPORTS   = 10;

  typedef logic [FEATS-1:0][FEAT_W-1:0] feat_row_t;

  // One input item; feat[0] is humidity, feat[5] surface proximity.
  typedef struct packed {
    func_t               func;
    logic [IN_IDX_W-1:0] entry;
    logic [DIM_W-1:0]    dim_word;
    feat_row_t           feat;
  } search_item_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] best_index;
    logic [DIST_W-1:0]    best_distance;
  } search_result_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [1:0]             s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  weighted_nearest_entry_search_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the entry tables and entry_count, updated as items are accepted.
  logic [FEAT_W-1:0] target_tbl [MAX_ENTRIES][FEATS];
  logic [FEAT_W-1:0] weight_tbl [MAX_ENTRIES][FEATS];
  logic [MASK_W-1:0] mask_tbl   [MAX_ENTRIES];
  int unsigned       table_count;

  search_item_t   pending_items [$];
  search_result_t expected_results [$];
  search_item_t   drive_item;

  bit          steady_feed = 1'b0;
  int          gap_left;
  int          burst_left;
  int          stall_left;
  int unsigned ready_cycle;
  int unsigned quiet_cycles;

  int unsigned items_sent;
  int unsigned searches_sent;
  int unsigned results_seen;
  int unsigned count_writes;
  int unsigned mismatch_count;
  int unsigned random_items;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A zero mask admits the entry everywhere; otherwise the dimension must be in
  // range and its bit set.
  function automatic bit entry_admits(int e, logic [DIM_W-1:0] dim);
    if (mask_tbl[e] == '0) return 1'b1;
    if (dim >= MASK_W || dim >= NUM_DIMENSIONS) return 1'b0;
    return mask_tbl[e][dim[MASK_IDX_W-1:0]];
  endfunction

  function automatic longint unsigned entry_distance(int e, search_item_t q);
    longint unsigned sum;
    int              t;
    int              f;
    int              d;
    int              k;
    sum = 0;
    for (k = 0; k < FEATS; k++) begin
      t = $signed(target_tbl[e][k]);
      f = $signed(q.feat[k]);
      d = (t > f) ? t - f : f - t;
      sum += 64'(d) * 64'(d) * 64'(weight_tbl[e][k]);
    end
    return sum;
  endfunction

  // Walk the entries in use; keep the first one with the strictly smallest sum.
  function automatic search_result_t nearest_entry(search_item_t q);
    search_result_t  r;
    longint unsigned d;
    longint unsigned best;
    bit              have;
    int unsigned     n;
    int              e;
    r    = '0;
    best = 0;
    have = 1'b0;
    n    = (table_count > MAX_ENTRIES) ? MAX_ENTRIES : table_count;
    for (e = 0; e < int'(n); e++) begin
      if (entry_admits(e, q.dim_word)) begin
        d = entry_distance(e, q);
        if (!have || d < best) begin
          have         = 1'b1;
          best         = d;
          r.best_index = OUT_IDX_W'(e);
        end
      end
    end
    r.found         = have;
    r.best_distance = best[DIST_W-1:0];
    return r;
  endfunction

  function automatic void absorb_item(search_item_t it);
    int k;
    items_sent++;
    case (it.func)
      FN_TARGETS: for (k = 0; k < FEATS; k++) target_tbl[it.entry][k] = it.feat[k];
      FN_WEIGHTS: for (k = 0; k < FEATS; k++) weight_tbl[it.entry][k] = it.feat[k];
      FN_MASK:    mask_tbl[it.entry] = it.dim_word;
      default: begin
        expected_results.push_back(nearest_entry(it));
        searches_sent++;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Item generation
  // ---------------------------------------------------------------------------

  function automatic feat_row_t fill_row(logic [FEAT_W-1:0] v);
    return {FEATS{v}};
  endfunction

  function automatic search_item_t make_item(func_t f, int e, logic [DIM_W-1:0] dim,
                                             feat_row_t row);
    search_item_t it;
    it.func     = f;
    it.entry    = IN_IDX_W'(e);
    it.dim_word = dim;
    it.feat     = row;
    return it;
  endfunction

  function automatic logic [FEAT_W-1:0] rand_feature();
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return FEAT_W'($urandom);
    endcase
  endfunction

  function automatic logic [FEAT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r < 10) return FEAT_W'($urandom_range(0, 16'h01FF));
    return FEAT_W'($urandom);
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 5) return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    if (r == 5) return '1;
    return MASK_W'($urandom);
  endfunction

  // Mostly in-range dimensions; the rest out of range, some with every bit random.
  function automatic logic [DIM_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return DIM_W'($urandom_range(0, NUM_DIMENSIONS - 1));
    if (r == 8) return DIM_W'($urandom_range(NUM_DIMENSIONS, 65535));
    return DIM_W'($urandom);
  endfunction

  // Searches often land close to an entry in use, so that small distances and
  // near ties come up.
  function automatic search_item_t make_search(int unsigned cnt);
    search_item_t it;
    int unsigned  n;
    int           e;
    int           k;
    it.func     = FN_QUERY;
    it.entry    = IN_IDX_W'($urandom);
    it.dim_word = rand_dim();
    n = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : cnt;
    if (n > 0 && $urandom_range(0, 99) < 40) begin
      e = $urandom_range(0, n - 1);
      for (k = 0; k < FEATS; k++)
        it.feat[k] = target_tbl[e][k] + FEAT_W'($urandom_range(0, 16)) - FEAT_W'(8);
    end else begin
      for (k = 0; k < FEATS; k++) it.feat[k] = rand_feature();
    end
    return it;
  endfunction

  // Table writes; a row is sometimes copied from another entry to force ties.
  function automatic search_item_t make_write();
    search_item_t it;
    int           src;
    bit           dup;
    int           k;
    it.func     = func_t'($urandom_range(0, 2));
    it.entry    = IN_IDX_W'($urandom);
    it.dim_word = DIM_W'($urandom);
    src = $urandom_range(0, MAX_ENTRIES - 1);
    dup = ($urandom_range(0, 4) == 0);
    for (k = 0; k < FEATS; k++) begin
      case (it.func)
        FN_TARGETS: it.feat[k] = dup ? target_tbl[src][k] : rand_feature();
        FN_WEIGHTS: it.feat[k] = dup ? weight_tbl[src][k] : rand_weight();
        default:    it.feat[k] = FEAT_W'($urandom);
      endcase
    end
    if (it.func == FN_MASK) it.dim_word = rand_mask();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------

  // Hold until every queued item is taken and every expected result is back,
  // then let the core settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(int unsigned v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    count_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps, or steady feed in some phases.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit next_valid;
    if (rst) begin
      s_tvalid    <= 1'b0;
      table_count = 0;
      gap_left    = 0;
      burst_left  = 0;
    end else begin
      // Track entry_count at the same edge the core takes it.
      if (cfg_we) table_count = cfg_wdata;
      if (s_tvalid && s_tready) absorb_item(drive_item);
      // Hold the current item until it is taken; only then pick the next one.
      if (!s_tvalid || s_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          drive_item = pending_items.pop_front();
          next_valid = 1'b1;
          if (!steady_feed) begin
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 23);
              gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                       : $urandom_range(1, 5);
            end
          end
        end
        s_tvalid <= next_valid;
        s_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, drive_item.feat,
                     drive_item.dim_word, drive_item.entry};
        s_tuser  <= drive_item.func;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result side, compare each result with the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    search_result_t got;
    search_result_t want;
    if (rst) begin
      m_tready    <= 1'b0;
      stall_left  = 0;
      ready_cycle = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.found         = m_tuser;
        got.best_index    = m_tdata[OUT_IDX_W-1:0];
        got.best_distance = m_tdata[OUT_IDX_W +: DIST_W];
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: found=%0d index=%0d distance=%0d",
                     got.found, got.best_index, got.best_distance);
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.best_index !== want.best_index ||
              got.best_distance !== want.best_distance) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch: expected found=%0d index=%0d distance=%0d, %s",
                       want.found, want.best_index, want.best_distance,
                       $sformatf("got found=%0d index=%0d distance=%0d",
                                 got.found, got.best_index, got.best_distance));
          end
        end
      end
      // One window in four runs without stalls.
      ready_cycle++;
      if ((ready_cycle / 4096) % 4 == 3) begin
        m_tready   <= 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1:    stall_left = $urandom_range(1, 4);
          2:       stall_left = $urandom_range(12, 40);
          default: stall_left = 0;
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("weighted_nearest_entry_search_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int           e;
    int unsigned  cnt;
    int           n;
    int           r;
    search_item_t seed;
    for (e = 0; e < MAX_ENTRIES; e++) begin
      mask_tbl[e] = '0;
      for (n = 0; n < FEATS; n++) begin
        target_tbl[e][n] = '0;
        weight_tbl[e][n] = '0;
      end
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty table: a search over zero entries finds nothing.
    set_entry_count(0);
    pending_items.push_back(make_search(0));

    // Three hand-built entries: most negative targets at full strictness and
    // no mask, most positive targets allowed only in the top dimension, and
    // zero targets with zero strictness allowed only in dimension zero.
    pending_items.push_back(make_item(FN_TARGETS, 0, 16'h0000, fill_row(16'h8000)));
    pending_items.push_back(make_item(FN_WEIGHTS, 0, 16'hFFFF, fill_row(16'hFFFF)));
    pending_items.push_back(make_item(FN_MASK,    0, 16'h0000, fill_row(16'hFFFF)));
    pending_items.push_back(make_item(FN_TARGETS, 1, 16'h5555, fill_row(16'h7FFF)));
    pending_items.push_back(make_item(FN_WEIGHTS, 1, 16'hAAAA, fill_row(16'hFFFF)));
    pending_items.push_back(make_item(FN_MASK,    1, 16'h8000, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_TARGETS, 2, 16'hFFFF, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_WEIGHTS, 2, 16'h0000, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_MASK,    2, 16'h0001, fill_row(16'h5A5A)));

    set_entry_count(3);
    // Exact hit on the top-dimension entry.
    pending_items.push_back(make_item(FN_QUERY, 63, 16'd15, fill_row(16'h7FFF)));
    // Zero-distance tie between entries 0 and 2: the lower index wins.
    pending_items.push_back(make_item(FN_QUERY, 0, 16'd0, fill_row(16'h8000)));
    // Largest possible distance, from entry 0 alone.
    pending_items.push_back(make_item(FN_QUERY, 21, 16'd3, fill_row(16'h7FFF)));
    // Out-of-range dimensions match only entries with a zero mask.
    pending_items.push_back(make_item(FN_QUERY, 0, 16'd16, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_QUERY, 0, 16'hFFFF, fill_row(16'h1234)));
    // Mask entry 0 down to one dimension; then nothing qualifies out of range.
    pending_items.push_back(make_item(FN_MASK,  0, 16'h4000, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_QUERY, 0, 16'hFFFF, fill_row(16'h0000)));
    pending_items.push_back(make_item(FN_QUERY, 0, 16'd14, fill_row(16'hC000)));

    // Single entry in use, masked out of dimension zero: no result found.
    set_entry_count(1);
    pending_items.push_back(make_item(FN_QUERY, 0, 16'd0, fill_row(16'h0000)));

    // Load every entry so that any entry_count is safe to search.
    for (e = 0; e < MAX_ENTRIES; e++) begin
      seed = make_search(0);
      pending_items.push_back(make_item(FN_TARGETS, e, DIM_W'($urandom), seed.feat));
      pending_items.push_back(make_item(FN_WEIGHTS, e, DIM_W'($urandom),
                                        {rand_weight(), rand_weight(), rand_weight(),
                                         rand_weight(), rand_weight(), rand_weight()}));
      seed = make_search(0);
      pending_items.push_back(make_item(FN_MASK, e, rand_mask(), seed.feat));
    end

    // Counts above the table size search the whole table.
    set_entry_count(127);
    repeat (6) pending_items.push_back(make_search(127));
    set_entry_count(65);
    repeat (4) pending_items.push_back(make_search(65));
    set_entry_count(MAX_ENTRIES);
    repeat (4) begin
      pending_items.push_back(make_write());
      pending_items.push_back(make_search(MAX_ENTRIES));
    end

    // Random phases: mostly small tables, a few full or oversized ones.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 5)       cnt = 0;
      else if (r < 70) cnt = $urandom_range(1, 8);
      else if (r < 88) cnt = $urandom_range(9, 32);
      else if (r < 94) cnt = MAX_ENTRIES;
      else             cnt = $urandom_range(MAX_ENTRIES + 1, 127);
      set_entry_count(cnt);
      steady_feed = ($urandom_range(0, 4) == 0);
      n = $urandom_range(16, 48);
      repeat (n) begin
        if ($urandom_range(0, 99) < 45) pending_items.push_back(make_search(cnt));
        else                            pending_items.push_back(make_write());
        random_items++;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d items (%0d searches, %0d table writes) over %0d entry_count settings",
             items_sent, searches_sent, items_sent - searches_sent, count_writes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("weighted_nearest_entry_search_core_test OK");
    end else begin
      $display("weighted_nearest_entry_search_core_test NOT OK");
    end
    $finish;
  end

endmodule
